// ===== rtl/keyed_slot_table_core_defines.svh =====
// Assertion macros for the keyed slot table core.
// Used by keyed_slot_table_core.sv; no other dependencies.
`ifndef KEYED_SLOT_TABLE_CORE_DEFINES_SVH
`define KEYED_SLOT_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the cycle after ante.
`define KST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keyed slot table: next-cycle check failed");

// Check that cons holds in the same cycle as ante.
`define KST_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keyed slot table: same-cycle check failed");

`else

`define KST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define KST_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/kst_pkg.sv =====
// Shared constants and codes for the keyed slot table core.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int TEXT_BYTES_DEF = 8;

    localparam int ACTION_W    = 2;
    localparam int KEY_W       = 16;
    localparam int TEXT_PORT_W = 64;
    localparam int STATUS_W    = 3;
    localparam int SLOT_IDX_W  = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_HIT      = 3'd2,
        ST_MISS     = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/kst_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on kst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kst_req_if;
    logic                            valid;
    logic                            ready;
    logic [kst_pkg::ACTION_W-1:0]    action;
    logic [kst_pkg::KEY_W-1:0]       node_key;
    logic [kst_pkg::TEXT_PORT_W-1:0] ident_text;
    logic [kst_pkg::TEXT_PORT_W-1:0] label_text;

    modport source (output valid, action, node_key, ident_text, label_text, input ready);
    modport sink   (input valid, action, node_key, ident_text, label_text, output ready);
endinterface

interface kst_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [kst_pkg::STATUS_W-1:0]    status;
    logic [kst_pkg::SLOT_IDX_W-1:0]  slot_index;
    logic [kst_pkg::TEXT_PORT_W-1:0] ident_out;
    logic [kst_pkg::TEXT_PORT_W-1:0] label_out;

    modport source (output valid, status, slot_index, ident_out, label_out, input ready);
    modport sink   (input valid, status, slot_index, ident_out, label_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/keyed_slot_table_core.sv =====
// Keyed slot table: add/update, find, remove and clear over SLOT_COUNT slots.
// Depends on kst_pkg, kst_if.sv and keyed_slot_table_core_defines.svh.
//
// Usage:
//   i_req carries one request item (action, node_key, ident_text, label_text);
//   o_rsp returns exactly one response item (status, slot_index, ident_out,
//   label_out) per request, in order. Both are valid/ready channels.
//   Keys sit in one synchronous memory, payloads in another; valid marks are
//   flip-flops. A non-clear request scans the key memory one slot per cycle,
//   lowest slot first, stopping at the first valid key match and noting the
//   lowest free slot on the way; then it writes or reads the payload memory.
//   A clear goes straight to the response without a scan; find and remove
//   pass through an extra payload-read state after a match, add does not.
//   One request is in work at a time; i_req.ready returns with the response.
//   The response sits in an output register, so the next request is taken
//   while a response waits; a stalled receiver holds the block only once a
//   second response is finished.
//   Reset clears all valid marks and the control state; memory contents are
//   left as they are and only read from valid slots.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_slot_table_core_defines.svh"

module keyed_slot_table_core #(
    parameter int SLOT_COUNT = kst_pkg::SLOT_COUNT_DEF,
    parameter int TEXT_BYTES = kst_pkg::TEXT_BYTES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    kst_req_if.sink    i_req,
    kst_rsp_if.source  o_rsp
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TEXT_W = 8 * TEXT_BYTES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_PAY,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [kst_pkg::STATUS_W-1:0]    status;
        logic [kst_pkg::SLOT_IDX_W-1:0]  slot_index;
        logic [kst_pkg::TEXT_PORT_W-1:0] ident;
        logic [kst_pkg::TEXT_PORT_W-1:0] label;
    } t_result;

    logic [kst_pkg::KEY_W-1:0] key_mem [SLOT_COUNT];
    logic [2*TEXT_W-1:0]       pay_mem [SLOT_COUNT];

    t_state                    r_state;
    logic [SLOT_COUNT-1:0]     r_valid;
    kst_pkg::t_action          r_action;
    logic [kst_pkg::KEY_W-1:0] r_key;
    logic [TEXT_W-1:0]         r_ident;
    logic [TEXT_W-1:0]         r_label;
    logic [IDX_W-1:0]          r_rd_idx;
    logic                      r_rd_done;
    logic                      r_cmp_en;
    logic [IDX_W-1:0]          r_cmp_idx;
    logic [kst_pkg::KEY_W-1:0] r_key_q;
    logic [2*TEXT_W-1:0]       r_pay_q;
    logic                      r_found;
    logic [IDX_W-1:0]          r_hit_idx;
    logic                      r_free_vld;
    logic [IDX_W-1:0]          r_free_idx;
    t_result                   r_res;
    t_result                   r_out;
    logic                      r_out_vld;

    logic             cmp_hit;
    logic             cmp_free;
    logic             key_rd;
    logic             key_we;
    logic             pay_we;
    logic             pay_rd;
    logic [IDX_W-1:0] wr_idx;
    logic             is_add;
    logic             is_lookup;
    logic             req_acc;
    logic             clr_acc;
    logic             scan_free;
    logic             rsp_empty;
    logic             rsp_zero;

    assign cmp_hit   = r_valid[r_cmp_idx] && (r_key_q == r_key);
    assign cmp_free  = !r_valid[r_cmp_idx];
    assign is_add    = (r_action == kst_pkg::ACT_ADD);
    assign is_lookup = (r_action == kst_pkg::ACT_FIND) || (r_action == kst_pkg::ACT_REMOVE);
    assign key_rd    = (r_state == S_SCAN) && !r_rd_done;
    assign key_we    = (r_state == S_ACT) && is_add && !r_found && r_free_vld;
    assign pay_we    = (r_state == S_ACT) && is_add && (r_found || r_free_vld);
    assign pay_rd    = (r_state == S_ACT) && is_lookup && r_found;
    assign wr_idx    = r_found ? r_hit_idx : r_free_idx;

    // key memory: one read port for the scan, one write port for insert
    always_ff @(posedge i_clk) begin
        if (key_rd) begin
            r_key_q <= key_mem[r_rd_idx];
        end
        if (key_we) begin
            key_mem[wr_idx] <= r_key;
        end
    end

    // payload memory: identifier in the upper half, label in the lower half
    always_ff @(posedge i_clk) begin
        if (pay_rd) begin
            r_pay_q <= pay_mem[r_hit_idx];
        end
        if (pay_we) begin
            pay_mem[wr_idx] <= {r_ident, r_label};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_rd_done  <= 1'b0;
            r_cmp_en   <= 1'b0;
            r_found    <= 1'b0;
            r_free_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_out_vld && o_rsp.ready && (r_state != S_EMIT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_action   <= kst_pkg::t_action'(i_req.action);
                        r_key      <= i_req.node_key;
                        r_ident    <= i_req.ident_text[TEXT_W-1:0];
                        r_label    <= i_req.label_text[TEXT_W-1:0];
                        r_found    <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_rd_idx   <= '0;
                        r_rd_done  <= 1'b0;
                        r_cmp_en   <= 1'b0;
                        if (i_req.action == kst_pkg::ACT_CLEAR) begin
                            r_valid <= '0;
                            r_res   <= '{status: kst_pkg::ST_CLEARED, slot_index: '0,
                                         ident: '0, label: '0};
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue the next key read, compare the one read last cycle
                    r_cmp_en <= !r_rd_done;
                    if (!r_rd_done) begin
                        r_cmp_idx <= r_rd_idx;
                        if (r_rd_idx == LAST_IDX) begin
                            r_rd_done <= 1'b1;
                        end else begin
                            r_rd_idx <= IDX_W'(r_rd_idx + 1'b1);
                        end
                    end
                    if (r_cmp_en) begin
                        if (cmp_hit) begin
                            r_found   <= 1'b1;
                            r_hit_idx <= r_cmp_idx;
                            r_state   <= S_ACT;
                        end else begin
                            if (cmp_free && !r_free_vld) begin
                                r_free_vld <= 1'b1;
                                r_free_idx <= r_cmp_idx;
                            end
                            if (r_cmp_idx == LAST_IDX) begin
                                r_state <= S_ACT;
                            end
                        end
                    end
                end
                S_ACT: begin
                    r_state <= S_EMIT;
                    if (is_add) begin
                        if (r_found) begin
                            r_res <= '{status: kst_pkg::ST_UPDATED,
                                       slot_index: kst_pkg::SLOT_IDX_W'(r_hit_idx),
                                       ident: kst_pkg::TEXT_PORT_W'(r_ident),
                                       label: kst_pkg::TEXT_PORT_W'(r_label)};
                        end else if (r_free_vld) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_res <= '{status: kst_pkg::ST_INSERTED,
                                       slot_index: kst_pkg::SLOT_IDX_W'(r_free_idx),
                                       ident: kst_pkg::TEXT_PORT_W'(r_ident),
                                       label: kst_pkg::TEXT_PORT_W'(r_label)};
                        end else begin
                            r_res <= '{status: kst_pkg::ST_FULL, slot_index: '0,
                                       ident: '0, label: '0};
                        end
                    end else if (r_found) begin
                        if (r_action == kst_pkg::ACT_REMOVE) begin
                            r_valid[r_hit_idx] <= 1'b0;
                        end
                        r_state <= S_PAY;
                    end else begin
                        r_res <= '{status: kst_pkg::ST_MISS, slot_index: '0,
                                   ident: '0, label: '0};
                    end
                end
                S_PAY: begin
                    r_res   <= '{status: kst_pkg::ST_HIT,
                                 slot_index: kst_pkg::SLOT_IDX_W'(r_hit_idx),
                                 ident: kst_pkg::TEXT_PORT_W'(r_pay_q[2*TEXT_W-1:TEXT_W]),
                                 label: kst_pkg::TEXT_PORT_W'(r_pay_q[TEXT_W-1:0])};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.slot_index = r_out.slot_index;
    assign o_rsp.ident_out  = r_out.ident;
    assign o_rsp.label_out  = r_out.label;

    assign req_acc   = i_req.valid && i_req.ready;
    assign clr_acc   = req_acc && (i_req.action == kst_pkg::ACT_CLEAR);
    assign scan_free = (r_state == S_SCAN) && r_free_vld;
    assign rsp_empty = o_rsp.valid && (o_rsp.status inside
                       {kst_pkg::ST_MISS, kst_pkg::ST_FULL, kst_pkg::ST_CLEARED});
    assign rsp_zero  = (o_rsp.slot_index == '0) && (o_rsp.ident_out == '0)
                       && (o_rsp.label_out == '0);

    `KST_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, req_acc, !i_req.ready)
    `KST_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, clr_acc, r_valid == '0)
    `KST_ASSERT_SAME(a_free_slot_empty, i_clk, i_rst_n, scan_free, !r_valid[r_free_idx])
    `KST_ASSERT_SAME(a_no_slot_zero_data, i_clk, i_rst_n, rsp_empty, rsp_zero)

endmodule

`default_nettype wire

// ===== tb/keyed_slot_table_checker.sv =====
// Checker for the keyed slot table core: watches the request and response channels,
// keeps its own copy of the slot table and compares every response item in order.
// Depends on kst_pkg for the action and status codes.
`timescale 1ns / 1ps

module keyed_slot_table_checker #(
    parameter int SLOT_COUNT = kst_pkg::SLOT_COUNT_DEF,
    parameter int TEXT_BYTES = kst_pkg::TEXT_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [kst_pkg::ACTION_W-1:0]    i_req_action,
    input  logic [kst_pkg::KEY_W-1:0]       i_req_key,
    input  logic [kst_pkg::TEXT_PORT_W-1:0] i_req_ident,
    input  logic [kst_pkg::TEXT_PORT_W-1:0] i_req_label,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [kst_pkg::STATUS_W-1:0]    i_rsp_status,
    input  logic [kst_pkg::SLOT_IDX_W-1:0]  i_rsp_slot,
    input  logic [kst_pkg::TEXT_PORT_W-1:0] i_rsp_ident,
    input  logic [kst_pkg::TEXT_PORT_W-1:0] i_rsp_label,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_full_seen
);

    localparam logic [kst_pkg::TEXT_PORT_W-1:0] TEXT_MASK = (TEXT_BYTES >= 8)
        ? {kst_pkg::TEXT_PORT_W{1'b1}}
        : ((64'd1 << (8 * TEXT_BYTES)) - 64'd1);

    typedef struct packed {
        kst_pkg::t_status                status;
        logic [kst_pkg::SLOT_IDX_W-1:0]  slot;
        logic [kst_pkg::TEXT_PORT_W-1:0] ident;
        logic [kst_pkg::TEXT_PORT_W-1:0] label;
    } t_table_reply;

    logic                            tbl_valid [SLOT_COUNT];
    logic [kst_pkg::KEY_W-1:0]       tbl_key   [SLOT_COUNT];
    logic [kst_pkg::TEXT_PORT_W-1:0] tbl_ident [SLOT_COUNT];
    logic [kst_pkg::TEXT_PORT_W-1:0] tbl_label [SLOT_COUNT];

    t_table_reply expected_replies [$];
    t_table_reply oldest_reply;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_seen  = 0;
    end

    function automatic t_table_reply apply_table_action(kst_pkg::t_action act,
                                                        logic [kst_pkg::KEY_W-1:0] key,
                                                        logic [kst_pkg::TEXT_PORT_W-1:0] ident,
                                                        logic [kst_pkg::TEXT_PORT_W-1:0] label);
        t_table_reply r;
        int           hit;
        int           free_slot;
        r.status = kst_pkg::ST_MISS;
        r.slot   = '0;
        r.ident  = '0;
        r.label  = '0;
        ident    = ident & TEXT_MASK;
        label    = label & TEXT_MASK;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
            if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
        end
        case (act)
            kst_pkg::ACT_ADD: begin
                if (hit >= 0) begin
                    tbl_ident[hit] = ident;
                    tbl_label[hit] = label;
                    r = '{kst_pkg::ST_UPDATED, hit[kst_pkg::SLOT_IDX_W-1:0], ident, label};
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_key[free_slot]   = key;
                    tbl_ident[free_slot] = ident;
                    tbl_label[free_slot] = label;
                    r = '{kst_pkg::ST_INSERTED, free_slot[kst_pkg::SLOT_IDX_W-1:0],
                          ident, label};
                end else begin
                    r.status = kst_pkg::ST_FULL;
                end
            end
            kst_pkg::ACT_FIND, kst_pkg::ACT_REMOVE: begin
                if (hit >= 0) begin
                    r = '{kst_pkg::ST_HIT, hit[kst_pkg::SLOT_IDX_W-1:0],
                          tbl_ident[hit], tbl_label[hit]};
                    if (act == kst_pkg::ACT_REMOVE) tbl_valid[hit] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
                r.status = kst_pkg::ST_CLEARED;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] response item with nothing outstanding: status %0d slot %0d",
                                 $realtime, i_rsp_status, i_rsp_slot);
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    o_checked++;
                    if (i_rsp_status != oldest_reply.status || i_rsp_slot != oldest_reply.slot ||
                        i_rsp_ident != oldest_reply.ident || i_rsp_label != oldest_reply.label) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("[%0t] mismatch: expected status %0d slot %0d ident %h label %h",
                                     $realtime, oldest_reply.status, oldest_reply.slot,
                                     oldest_reply.ident, oldest_reply.label);
                            $display("            got      status %0d slot %0d ident %h label %h",
                                     i_rsp_status, i_rsp_slot, i_rsp_ident, i_rsp_label);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_replies.push_back(apply_table_action(kst_pkg::t_action'(i_req_action),
                                                              i_req_key, i_req_ident,
                                                              i_req_label));
                if (expected_replies[$].status == kst_pkg::ST_FULL) o_full_seen++;
            end
        end
        o_pending = expected_replies.size();
    end

endmodule

// ===== tb/keyed_slot_table_core_test.sv =====
// Top of the keyed slot table core test: clock, reset, request stimulus and
// response back-pressure, with keyed_slot_table_checker predicting and comparing.
// Depends on kst_pkg, kst_if.sv, keyed_slot_table_core and the checker.
`timescale 1ns / 1ps

module keyed_slot_table_core_test;

    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int KEY_POOL    = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kst_req_if req_ch ();
    kst_rsp_if rsp_ch ();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_off_armed = 1'b0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int fail_count;
    int pending_count;
    int checked_count;
    int full_count;

    logic [kst_pkg::KEY_W-1:0] key_pool [KEY_POOL];

    keyed_slot_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    keyed_slot_table_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_action (req_ch.action),
        .i_req_key    (req_ch.node_key),
        .i_req_ident  (req_ch.ident_text),
        .i_req_label  (req_ch.label_text),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_rsp_status (rsp_ch.status),
        .i_rsp_slot   (rsp_ch.slot_index),
        .i_rsp_ident  (rsp_ch.ident_out),
        .i_rsp_label  (rsp_ch.label_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_full_seen  (full_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycle_count, pending_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // hold off once for a long stretch, else stall at the phase rate
    initial begin
        int hold_left;
        rsp_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_off_armed) begin
                hold_off_armed = 1'b0;
                rsp_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(negedge i_clk);
                    hold_left--;
                end
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic offer_request(input kst_pkg::t_action act,
                                 input logic [kst_pkg::KEY_W-1:0] key,
                                 input logic [kst_pkg::TEXT_PORT_W-1:0] ident,
                                 input logic [kst_pkg::TEXT_PORT_W-1:0] label);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.node_key   <= key;
        req_ch.ident_text <= ident;
        req_ch.label_text <= label;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [kst_pkg::TEXT_PORT_W-1:0] rand_text();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [kst_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
        return kst_pkg::KEY_W'($urandom_range(16'hFFFF));
    endfunction

    initial begin
        int               roll;
        kst_pkg::t_action act;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = kst_pkg::ACT_ADD;
        req_ch.node_key   = '0;
        req_ch.ident_text = '0;
        req_ch.label_text = '0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = kst_pkg::KEY_W'($urandom_range(16'hFFFF));
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // clear on empty, extreme keys and texts, update, hit and miss paths
        offer_request(kst_pkg::ACT_CLEAR, 16'h0000, '0, '0);
        offer_request(kst_pkg::ACT_ADD, 16'h0000, '0, '0);
        offer_request(kst_pkg::ACT_ADD, 16'hFFFF, '1, '1);
        offer_request(kst_pkg::ACT_ADD, 16'hFFFF, rand_text(), rand_text());
        offer_request(kst_pkg::ACT_FIND, 16'hFFFF, '0, '0);
        offer_request(kst_pkg::ACT_FIND, 16'h1234, '0, '0);
        offer_request(kst_pkg::ACT_REMOVE, 16'h0000, '0, '0);
        offer_request(kst_pkg::ACT_REMOVE, 16'h0000, '0, '0);
        // fill every slot, then overflow, then reach the top slot
        for (int k = 1; k <= 15; k++) begin
            offer_request(kst_pkg::ACT_ADD, k[kst_pkg::KEY_W-1:0], rand_text(), rand_text());
        end
        offer_request(kst_pkg::ACT_ADD, 16'h8000, rand_text(), rand_text());
        offer_request(kst_pkg::ACT_FIND, 16'd15, '0, '0);
        offer_request(kst_pkg::ACT_REMOVE, 16'd15, '0, '0);
        offer_request(kst_pkg::ACT_CLEAR, 16'hFFFF, '1, '1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    stall_pct      = 0;
                    hold_off_armed = 1'b1;
                end
                1: begin
                    send_idle_pct = 70;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 70;
                end
                default: begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 45) act = kst_pkg::ACT_ADD;
                else if (roll < 70) act = kst_pkg::ACT_FIND;
                else if (roll < 98) act = kst_pkg::ACT_REMOVE;
                else act = kst_pkg::ACT_CLEAR;
                offer_request(act, pick_key(), rand_text(), rand_text());
            end
        end
        req_ch.valid <= 1'b0;
        stall_pct = 0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests over four handshake mixes and one long receiver hold-off",
                 items_sent);
        $display("compared %0d responses, %0d of them with the table full", checked_count,
                 full_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kst_pkg.sv
rtl/kst_if.sv
rtl/keyed_slot_table_core.sv
tb/keyed_slot_table_checker.sv
tb/keyed_slot_table_core_test.sv
